// ===== src/bbps_pkg.sv =====
// Shared types, widths and reset constants for the battery boost power sequencer.
package bbps_pkg;

   localparam int SAMPLES_PER_TICK_DEFAULT = 15;

   localparam int ADC_W      = 10;
   localparam int TIME_W     = 32;
   localparam int CV_W       = 9;
   localparam int PHASE_W    = 3;
   localparam int SUM_W      = 14;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic [CV_W-1:0]   CHARGE_FULL_CV_RESET = CV_W'(350);
   localparam logic [CV_W-1:0]   LOW_LIMIT_CV_RESET   = CV_W'(280);
   localparam logic [CV_W-1:0]   DISCONNECT_CV_RESET  = CV_W'(50);
   localparam logic [TIME_W-1:0] STEPUP_TIME_RESET    = TIME_W'(20000);
   localparam logic [TIME_W-1:0] GRACE_TIME_RESET     = TIME_W'(20000);
   localparam logic [ADC_W-1:0]  NO_SUPPLY_CODE_RESET = ADC_W'(1020);

   localparam logic [CV_W-1:0]   NO_SUPPLY_CV = CV_W'(1);

   typedef enum logic [2:0] {
      REG_CHARGE_FULL_CV = 3'd0,
      REG_LOW_LIMIT_CV   = 3'd1,
      REG_DISCONNECT_CV  = 3'd2,
      REG_STEPUP_TIME_MS = 3'd3,
      REG_GRACE_TIME_MS  = 3'd4,
      REG_NO_SUPPLY_CODE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ADC_W-1:0]  adc_sample;
      logic [TIME_W-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic               tick_done;
      logic [PHASE_W-1:0] phase_code;
      logic               charge_on;
      logic               stepup_on;
      logic               meter_power_on;
      logic [CV_W-1:0]    batt_cv;
   } rsp_word_type;

   typedef struct packed {
      logic [CV_W-1:0]   charge_full_cv;
      logic [CV_W-1:0]   low_limit_cv;
      logic [CV_W-1:0]   disconnect_cv;
      logic [TIME_W-1:0] stepup_time_ms;
      logic [TIME_W-1:0] grace_time_ms;
      logic [ADC_W-1:0]  no_supply_code;
   } cfg_type;

   typedef struct packed {
      logic            step;
      logic [CV_W-1:0] cv;
   } tick_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_code;
      logic               charge_on;
      logic               stepup_on;
      logic               meter_power_on;
   } status_type;

endpackage

// ===== src/bbps_csr.sv =====
// Configuration register file behind the APB-style port.
module bbps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bbps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bbps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bbps_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output bbps_pkg::cfg_type                   cfg
);

   bbps_pkg::cfg_type       cfg_ff;
   bbps_pkg::cfg_type       cfg_in;
   bbps_pkg::csr_index_type index;
   logic                    write_en;

   assign index    = bbps_pkg::csr_index_type'(paddr[bbps_pkg::CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            bbps_pkg::REG_CHARGE_FULL_CV: cfg_in.charge_full_cv = pwdata[bbps_pkg::CV_W-1:0];
            bbps_pkg::REG_LOW_LIMIT_CV:   cfg_in.low_limit_cv   = pwdata[bbps_pkg::CV_W-1:0];
            bbps_pkg::REG_DISCONNECT_CV:  cfg_in.disconnect_cv  = pwdata[bbps_pkg::CV_W-1:0];
            bbps_pkg::REG_STEPUP_TIME_MS: cfg_in.stepup_time_ms = pwdata[bbps_pkg::TIME_W-1:0];
            bbps_pkg::REG_GRACE_TIME_MS:  cfg_in.grace_time_ms  = pwdata[bbps_pkg::TIME_W-1:0];
            bbps_pkg::REG_NO_SUPPLY_CODE: cfg_in.no_supply_code = pwdata[bbps_pkg::ADC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bbps_pkg::REG_CHARGE_FULL_CV: prdata = bbps_pkg::CSR_DATA_W'(cfg_ff.charge_full_cv);
         bbps_pkg::REG_LOW_LIMIT_CV:   prdata = bbps_pkg::CSR_DATA_W'(cfg_ff.low_limit_cv);
         bbps_pkg::REG_DISCONNECT_CV:  prdata = bbps_pkg::CSR_DATA_W'(cfg_ff.disconnect_cv);
         bbps_pkg::REG_STEPUP_TIME_MS: prdata = bbps_pkg::CSR_DATA_W'(cfg_ff.stepup_time_ms);
         bbps_pkg::REG_GRACE_TIME_MS:  prdata = bbps_pkg::CSR_DATA_W'(cfg_ff.grace_time_ms);
         bbps_pkg::REG_NO_SUPPLY_CODE: prdata = bbps_pkg::CSR_DATA_W'(cfg_ff.no_supply_code);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_full_cv <= bbps_pkg::CHARGE_FULL_CV_RESET;
         cfg_ff.low_limit_cv   <= bbps_pkg::LOW_LIMIT_CV_RESET;
         cfg_ff.disconnect_cv  <= bbps_pkg::DISCONNECT_CV_RESET;
         cfg_ff.stepup_time_ms <= bbps_pkg::STEPUP_TIME_RESET;
         cfg_ff.grace_time_ms  <= bbps_pkg::GRACE_TIME_RESET;
         cfg_ff.no_supply_code <= bbps_pkg::NO_SUPPLY_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/bbps_avg.sv =====
// Sample accumulator, group average by reciprocal multiply, and code to centivolt scaling.
module bbps_avg #(
   parameter int SAMPLES_PER_TICK = bbps_pkg::SAMPLES_PER_TICK_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [bbps_pkg::ADC_W-1:0]     adc_sample,
   input  logic [bbps_pkg::ADC_W-1:0]     no_supply_code,
   output bbps_pkg::tick_type             tick,
   output logic [bbps_pkg::CV_W-1:0]      batt_cv
);

   localparam int CNT_W      = (SAMPLES_PER_TICK > 1) ? $clog2(SAMPLES_PER_TICK) : 1;
   localparam int DIV_SHIFT  = bbps_pkg::SUM_W + CNT_W;
   localparam int MUL_W      = DIV_SHIFT + 1;
   localparam int DIV_MULT   = ((2 ** DIV_SHIFT) + SAMPLES_PER_TICK - 1) / SAMPLES_PER_TICK;
   localparam int PROD_W     = bbps_pkg::SUM_W + MUL_W;
   localparam int SCALE_W    = bbps_pkg::ADC_W + 9;

   logic [bbps_pkg::SUM_W-1:0] sum_ff;
   logic [bbps_pkg::SUM_W-1:0] sum_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [bbps_pkg::CV_W-1:0]  last_cv_ff;
   logic [bbps_pkg::CV_W-1:0]  last_cv_in;

   logic [bbps_pkg::SUM_W-1:0] sum_total;
   logic                       last_sample;
   logic [PROD_W-1:0]          quot_prod;
   logic [bbps_pkg::ADC_W-1:0] avg;
   logic [SCALE_W-1:0]         avg_ext;
   logic [SCALE_W-1:0]         scaled;
   logic [bbps_pkg::CV_W-1:0]  cv_new;

   assign sum_total   = sum_ff + bbps_pkg::SUM_W'(adc_sample);
   assign last_sample = (count_ff == CNT_W'(SAMPLES_PER_TICK - 1));

   // floor(sum / N) as (sum * ceil(2^S / N)) >> S, exact over the whole sum range
   assign quot_prod = PROD_W'(sum_total) * PROD_W'(DIV_MULT);
   assign avg       = quot_prod[DIV_SHIFT +: bbps_pkg::ADC_W];

   // avg * 500 = avg * 512 - avg * 8 - avg * 4
   assign avg_ext = SCALE_W'(avg);
   assign scaled  = (avg_ext << 9) - (avg_ext << 3) - (avg_ext << 2);
   assign cv_new  = (avg >= no_supply_code) ? bbps_pkg::NO_SUPPLY_CV
                                            : scaled[SCALE_W-1 -: bbps_pkg::CV_W];

   assign tick.step = advance && last_sample;
   assign tick.cv   = cv_new;
   assign batt_cv   = last_cv_in;

   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      last_cv_in = last_cv_ff;
      if (advance) begin
         if (last_sample) begin
            sum_in     = '0;
            count_in   = '0;
            last_cv_in = cv_new;
         end else begin
            sum_in   = sum_total;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         count_ff   <= '0;
         last_cv_ff <= '0;
      end else begin
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         last_cv_ff <= last_cv_in;
      end
   end

endmodule

// ===== src/bbps_seq.sv =====
// Power sequencer state machine with wrap-safe step-up and grace timeouts.
module bbps_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  bbps_pkg::tick_type             tick,
   input  logic [bbps_pkg::TIME_W-1:0]    now_ms,
   input  bbps_pkg::cfg_type              cfg,
   output bbps_pkg::status_type           status
);

   typedef enum logic [bbps_pkg::PHASE_W-1:0] {
      PH_INIT         = 3'd0,
      PH_CHARGE       = 3'd1,
      PH_START_STEPUP = 3'd2,
      PH_STEPUP       = 3'd3,
      PH_METER        = 3'd4,
      PH_NORMAL       = 3'd5
   } phase_type;

   phase_type                   phase_ff;
   phase_type                   phase_in;
   phase_type                   phase_cur;
   logic [bbps_pkg::TIME_W-1:0] stepup_start_ff;
   logic [bbps_pkg::TIME_W-1:0] stepup_start_in;
   logic [bbps_pkg::TIME_W-1:0] grace_start_ff;
   logic [bbps_pkg::TIME_W-1:0] grace_start_in;
   logic                        charge_ff;
   logic                        charge_in;
   logic                        stepup_ff;
   logic                        stepup_in;
   logic                        meter_ff;
   logic                        meter_in;
   logic [bbps_pkg::TIME_W-1:0] stepup_elapsed;
   logic [bbps_pkg::TIME_W-1:0] grace_elapsed;

   assign stepup_elapsed = now_ms - stepup_start_ff;
   assign grace_elapsed  = now_ms - grace_start_ff;
   assign phase_cur      = (tick.cv < cfg.disconnect_cv) ? PH_INIT : phase_ff;

   always_comb begin
      phase_in        = phase_ff;
      stepup_start_in = stepup_start_ff;
      grace_start_in  = grace_start_ff;
      charge_in       = charge_ff;
      stepup_in       = stepup_ff;
      meter_in        = meter_ff;
      if (tick.step) begin
         unique case (phase_cur)
            PH_INIT: begin
               charge_in = 1'b1;
               stepup_in = 1'b0;
               meter_in  = 1'b0;
               phase_in  = PH_CHARGE;
            end
            PH_CHARGE: begin
               charge_in = 1'b1;
               stepup_in = 1'b0;
               meter_in  = 1'b0;
               if (tick.cv >= cfg.charge_full_cv) begin
                  stepup_start_in = now_ms;
                  phase_in        = PH_START_STEPUP;
               end
            end
            PH_START_STEPUP: begin
               charge_in = 1'b1;
               stepup_in = 1'b1;
               meter_in  = 1'b0;
               phase_in  = PH_STEPUP;
            end
            PH_STEPUP: begin
               if (tick.cv < cfg.low_limit_cv) begin
                  phase_in = PH_INIT;
               end else if (stepup_elapsed > cfg.stepup_time_ms) begin
                  phase_in = PH_METER;
               end
            end
            PH_METER: begin
               meter_in       = 1'b1;
               grace_start_in = now_ms;
               phase_in       = PH_NORMAL;
            end
            default: begin
               if (grace_elapsed > cfg.grace_time_ms) begin
                  charge_in = 1'b1;
               end
            end
         endcase
      end
   end

   assign status.phase_code     = phase_in;
   assign status.charge_on      = charge_in;
   assign status.stepup_on      = stepup_in;
   assign status.meter_power_on = meter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_INIT;
         stepup_start_ff <= '0;
         grace_start_ff  <= '0;
         charge_ff       <= 1'b1;
         stepup_ff       <= 1'b0;
         meter_ff        <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         stepup_start_ff <= stepup_start_in;
         grace_start_ff  <= grace_start_in;
         charge_ff       <= charge_in;
         stepup_ff       <= stepup_in;
         meter_ff        <= meter_in;
      end
   end

   a_charge_drive: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CHARGE |-> charge_ff && !stepup_ff && !meter_ff)
      else $error("charge phase with wrong switch drive");

   a_stepup_drive: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_STEPUP || phase_ff == PH_METER) |-> stepup_ff && !meter_ff)
      else $error("step-up phase with wrong switch drive");

   a_normal_drive: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_NORMAL |-> stepup_ff && meter_ff)
      else $error("normal phase without step-up and meter power");

endmodule

// ===== src/battery_boost_power_sequencer_core.sv =====
// Top level of the battery boost power sequencer: input register, result register, datapath.
//
//   port group | direction | word
//   req_*      | in        | req_word_type: adc_sample, now_ms
//   rsp_*      | out       | rsp_word_type: tick_done, phase, switch drives, batt_cv
//   APB        | in/out    | six configuration registers at byte address 4*i
//
// One word per cycle while rsp_stall is low; each word passes through the input register
// and then the result register before it appears on rsp_*.
// The averaging multiply, scaling and sequencer step sit between the two registers.
// Synchronous reset clears valids and sequencer state; the block is ready right away.
// rsp_stall holds the result register; req_stall rises only when both registers are full.
module battery_boost_power_sequencer_core #(
   parameter int SAMPLES_PER_TICK = bbps_pkg::SAMPLES_PER_TICK_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bbps_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bbps_pkg::rsp_word_type              rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bbps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bbps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bbps_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   bbps_pkg::req_word_type in_word_ff;
   bbps_pkg::req_word_type in_word_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   bbps_pkg::rsp_word_type rsp_word_ff;
   bbps_pkg::rsp_word_type rsp_word_in;

   logic                       advance;
   logic                       req_accept;
   bbps_pkg::cfg_type          cfg;
   bbps_pkg::tick_type         tick;
   bbps_pkg::status_type       status;
   logic [bbps_pkg::CV_W-1:0]  batt_cv;

   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_word_ff;

   bbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bbps_avg #(
      .SAMPLES_PER_TICK (SAMPLES_PER_TICK)
   ) u_avg (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .adc_sample     (in_word_ff.adc_sample),
      .no_supply_code (cfg.no_supply_code),
      .tick           (tick),
      .batt_cv        (batt_cv)
   );

   bbps_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .now_ms (in_word_ff.now_ms),
      .cfg    (cfg),
      .status (status)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_word_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.tick_done      = tick.step;
         rsp_word_in.phase_code     = status.phase_code;
         rsp_word_in.charge_on      = status.charge_on;
         rsp_word_in.stepup_on      = status.stepup_on;
         rsp_word_in.meter_power_on = status.meter_power_on;
         rsp_word_in.batt_cv        = batt_cv;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word did not reach the result register");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && in_valid_ff)
      else $error("input stalled with a free register");

   a_tick_updates_cv: assert property (@(posedge clock) disable iff (reset)
      !tick.step && advance |-> batt_cv == $past(batt_cv) || $past(reset))
      else $error("battery voltage changed without a completed group");

endmodule

// ===== test/tb_battery_boost_power_sequencer_core.sv =====
// Testbench for the battery boost power sequencer core: random sample stream, APB setup, scoreboard.
module tb_battery_boost_power_sequencer_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD = 6;
   localparam int TICK_SAMPLES = bbps_pkg::SAMPLES_PER_TICK_DEFAULT;
   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum logic [bbps_pkg::PHASE_W-1:0] {
      PH_INIT         = 3'd0,
      PH_CHARGE       = 3'd1,
      PH_START_STEPUP = 3'd2,
      PH_STEPUP       = 3'd3,
      PH_METER        = 3'd4,
      PH_NORMAL       = 3'd5
   } seq_phase_type;

   class sequencer_scoreboard;
      bbps_pkg::rsp_word_type              status_q[$];
      bbps_pkg::cfg_type                   cfg;
      logic [bbps_pkg::SUM_W-1:0]          sample_sum;
      int unsigned                         sample_count;
      seq_phase_type                       phase;
      logic [bbps_pkg::TIME_W-1:0]         stepup_t0;
      logic [bbps_pkg::TIME_W-1:0]         grace_t0;
      logic                                charge_sw;
      logic                                stepup_sw;
      logic                                meter_sw;
      logic [bbps_pkg::CV_W-1:0]           last_cv;
      int                                  errors;
      int                                  words_checked;

      function new();
         cfg.charge_full_cv = bbps_pkg::CHARGE_FULL_CV_RESET;
         cfg.low_limit_cv   = bbps_pkg::LOW_LIMIT_CV_RESET;
         cfg.disconnect_cv  = bbps_pkg::DISCONNECT_CV_RESET;
         cfg.stepup_time_ms = bbps_pkg::STEPUP_TIME_RESET;
         cfg.grace_time_ms  = bbps_pkg::GRACE_TIME_RESET;
         cfg.no_supply_code = bbps_pkg::NO_SUPPLY_CODE_RESET;
         sample_sum = '0;
         sample_count = 0;
         phase = PH_INIT;
         stepup_t0 = '0;
         grace_t0 = '0;
         charge_sw = 1'b1;
         stepup_sw = 1'b0;
         meter_sw = 1'b0;
         last_cv = '0;
         errors = 0;
         words_checked = 0;
      endfunction

      function void set_reg(bbps_pkg::csr_index_type idx,
                            logic [bbps_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            bbps_pkg::REG_CHARGE_FULL_CV: cfg.charge_full_cv = v[bbps_pkg::CV_W-1:0];
            bbps_pkg::REG_LOW_LIMIT_CV:   cfg.low_limit_cv = v[bbps_pkg::CV_W-1:0];
            bbps_pkg::REG_DISCONNECT_CV:  cfg.disconnect_cv = v[bbps_pkg::CV_W-1:0];
            bbps_pkg::REG_STEPUP_TIME_MS: cfg.stepup_time_ms = v[bbps_pkg::TIME_W-1:0];
            bbps_pkg::REG_GRACE_TIME_MS:  cfg.grace_time_ms = v[bbps_pkg::TIME_W-1:0];
            bbps_pkg::REG_NO_SUPPLY_CODE: cfg.no_supply_code = v[bbps_pkg::ADC_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      function void take_sample(bbps_pkg::req_word_type w);
         bbps_pkg::rsp_word_type      r;
         logic [bbps_pkg::ADC_W-1:0]  avg;
         logic [bbps_pkg::CV_W-1:0]   cv;
         logic                        tick;
         tick = 1'b0;
         sample_sum = sample_sum + bbps_pkg::SUM_W'(w.adc_sample);
         sample_count++;
         if (sample_count >= TICK_SAMPLES) begin
            avg = bbps_pkg::ADC_W'(sample_sum / TICK_SAMPLES);
            sample_sum = '0;
            sample_count = 0;
            if (avg >= cfg.no_supply_code) cv = bbps_pkg::NO_SUPPLY_CV;
            else cv = bbps_pkg::CV_W'((32'(avg) * 32'd500) >> 10);
            last_cv = cv;
            if (cv < cfg.disconnect_cv) phase = PH_INIT;
            case (phase)
               PH_INIT: begin
                  charge_sw = 1'b1;
                  stepup_sw = 1'b0;
                  meter_sw = 1'b0;
                  phase = PH_CHARGE;
               end
               PH_CHARGE: begin
                  charge_sw = 1'b1;
                  stepup_sw = 1'b0;
                  meter_sw = 1'b0;
                  if (cv >= cfg.charge_full_cv) begin
                     stepup_t0 = w.now_ms;
                     phase = PH_START_STEPUP;
                  end
               end
               PH_START_STEPUP: begin
                  stepup_sw = 1'b1;
                  charge_sw = 1'b1;
                  meter_sw = 1'b0;
                  phase = PH_STEPUP;
               end
               PH_STEPUP: begin
                  if (cv < cfg.low_limit_cv) phase = PH_INIT;
                  else if (bbps_pkg::TIME_W'(w.now_ms - stepup_t0) > cfg.stepup_time_ms)
                     phase = PH_METER;
               end
               PH_METER: begin
                  meter_sw = 1'b1;
                  grace_t0 = w.now_ms;
                  phase = PH_NORMAL;
               end
               default: begin
                  if (bbps_pkg::TIME_W'(w.now_ms - grace_t0) > cfg.grace_time_ms)
                     charge_sw = 1'b1;
               end
            endcase
            tick = 1'b1;
         end
         r.tick_done = tick;
         r.phase_code = phase;
         r.charge_on = charge_sw;
         r.stepup_on = stepup_sw;
         r.meter_power_on = meter_sw;
         r.batt_cv = last_cv;
         status_q.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch at word %0d: %s", words_checked, what);
         errors++;
      endtask

      task check_status(bbps_pkg::rsp_word_type got);
         bbps_pkg::rsp_word_type want;
         if (status_q.size() == 0) begin
            report($sformatf("unrequested word %h", got));
         end else begin
            want = status_q.pop_front();
            if (got.tick_done !== want.tick_done)
               report($sformatf("tick_done %b, want %b", got.tick_done, want.tick_done));
            if (got.phase_code !== want.phase_code)
               report($sformatf("phase_code %0d, want %0d", got.phase_code, want.phase_code));
            if (got.charge_on !== want.charge_on)
               report($sformatf("charge_on %b, want %b", got.charge_on, want.charge_on));
            if (got.stepup_on !== want.stepup_on)
               report($sformatf("stepup_on %b, want %b", got.stepup_on, want.stepup_on));
            if (got.meter_power_on !== want.meter_power_on)
               report($sformatf("meter_power_on %b, want %b",
                                got.meter_power_on, want.meter_power_on));
            if (got.batt_cv !== want.batt_cv)
               report($sformatf("batt_cv %0d, want %0d", got.batt_cv, want.batt_cv));
         end
         words_checked++;
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   bbps_pkg::req_word_type          req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   bbps_pkg::rsp_word_type          rsp_data;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [bbps_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [bbps_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [bbps_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   sequencer_scoreboard             sb = new();
   bit                              req_idle_en = 1'b1;
   bit                              rsp_idle_en = 1'b1;
   bit                              long_hold_req = 1'b0;
   int                              quiet_cycles = 0;
   logic [bbps_pkg::TIME_W-1:0]     now_ms = '0;

   battery_boost_power_sequencer_core #(
      .SAMPLES_PER_TICK(TICK_SAMPLES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_status(rsp_data);
         if (req_valid && !req_stall) sb.take_sample(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always begin
      @(posedge clock);
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_stall <= 1'b1;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         rsp_stall <= 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 18)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task send_word(bbps_pkg::req_word_type w);
      if (req_idle_en && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   task csr_write(bbps_pkg::csr_index_type idx, logic [bbps_pkg::CSR_DATA_W-1:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= bbps_pkg::CSR_ADDR_W'(4 * int'(idx));
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, v);
   endtask

   task program_config(bbps_pkg::cfg_type c);
      logic [bbps_pkg::CSR_DATA_W-1:0] v;
      v = $urandom;
      v[bbps_pkg::CV_W-1:0] = c.charge_full_cv;
      csr_write(bbps_pkg::REG_CHARGE_FULL_CV, v);
      v = $urandom;
      v[bbps_pkg::CV_W-1:0] = c.low_limit_cv;
      csr_write(bbps_pkg::REG_LOW_LIMIT_CV, v);
      v = $urandom;
      v[bbps_pkg::CV_W-1:0] = c.disconnect_cv;
      csr_write(bbps_pkg::REG_DISCONNECT_CV, v);
      csr_write(bbps_pkg::REG_STEPUP_TIME_MS, c.stepup_time_ms);
      csr_write(bbps_pkg::REG_GRACE_TIME_MS, c.grace_time_ms);
      v = $urandom;
      v[bbps_pkg::ADC_W-1:0] = c.no_supply_code;
      csr_write(bbps_pkg::REG_NO_SUPPLY_CODE, v);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Most groups hold one battery level with a little noise, a few are random samples; most levels
   // sit high enough to walk the sequencer forward, some dip around the low limit or to disconnect.
   task run_groups(int n, int unsigned step_max);
      int unsigned            base;
      int unsigned            kind;
      int                     lvl;
      bbps_pkg::req_word_type w;
      for (int g = 0; g < n; g++) begin
         kind = $urandom_range(0, 19);
         if (kind < 12) base = $urandom_range(720, 1023);
         else if (kind < 16) base = $urandom_range(560, 740);
         else if (kind < 18) base = $urandom_range(0, 110);
         else base = 1024;
         for (int s = 0; s < TICK_SAMPLES; s++) begin
            if (base == 1024) begin
               w.adc_sample = bbps_pkg::ADC_W'($urandom);
            end else begin
               lvl = int'(base) + int'($urandom_range(0, 24)) - 12;
               if (lvl < 0) lvl = 0;
               if (lvl > 1023) lvl = 1023;
               w.adc_sample = bbps_pkg::ADC_W'(lvl);
            end
            if ($urandom_range(0, 49) == 0) now_ms = $urandom;
            else now_ms = now_ms + bbps_pkg::TIME_W'($urandom_range(0, step_max));
            w.now_ms = now_ms;
            send_word(w);
         end
      end
   endtask

   function automatic bbps_pkg::cfg_type random_setting();
      bbps_pkg::cfg_type c;
      c.charge_full_cv = bbps_pkg::CV_W'($urandom_range(0, 511));
      c.low_limit_cv = bbps_pkg::CV_W'($urandom_range(0, 511));
      c.disconnect_cv = bbps_pkg::CV_W'($urandom_range(0, 120));
      c.stepup_time_ms = ($urandom_range(0, 3) == 0) ? bbps_pkg::TIME_W'($urandom)
                                  : bbps_pkg::TIME_W'($urandom_range(0, 8000));
      c.grace_time_ms = ($urandom_range(0, 3) == 0) ? bbps_pkg::TIME_W'($urandom)
                                 : bbps_pkg::TIME_W'($urandom_range(0, 8000));
      c.no_supply_code = bbps_pkg::ADC_W'($urandom_range(700, 1023));
      return c;
   endfunction

   initial begin : stimulus
      bbps_pkg::req_word_type w;
      bbps_pkg::cfg_type      c;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // no supply at full scale with time stamps at both ends of the range
      for (int i = 0; i < TICK_SAMPLES; i++) begin
         w.adc_sample = '1;
         w.now_ms = (i % 2 == 0) ? '1 : '0;
         send_word(w);
      end
      for (int i = 0; i < 10; i++) begin
         w.adc_sample = '0;
         w.now_ms = bbps_pkg::TIME_W'($urandom);
         send_word(w);
      end
      drain();

      c = '{charge_full_cv: 9'd350, low_limit_cv: 9'd280, disconnect_cv: 9'd50,
            stepup_time_ms: 32'd3000, grace_time_ms: 32'd5000, no_supply_code: 10'd1020};
      program_config(c);
      now_ms = $urandom;
      run_groups(3, 800);
      long_hold_req = 1'b1;
      run_groups(3, 800);
      drain();
      run_groups(4, 800);
      drain();

      c = '{charge_full_cv: bbps_pkg::CHARGE_FULL_CV_RESET,
            low_limit_cv: bbps_pkg::LOW_LIMIT_CV_RESET,
            disconnect_cv: bbps_pkg::DISCONNECT_CV_RESET,
            stepup_time_ms: bbps_pkg::STEPUP_TIME_RESET,
            grace_time_ms: bbps_pkg::GRACE_TIME_RESET,
            no_supply_code: bbps_pkg::NO_SUPPLY_CODE_RESET};
      program_config(c);
      now_ms = 32'hFFFF_0000;
      run_groups(10, 3000);
      drain();

      c = '{charge_full_cv: '0, low_limit_cv: '0, disconnect_cv: '0,
            stepup_time_ms: '0, grace_time_ms: '0, no_supply_code: '0};
      program_config(c);
      run_groups(6, 50);
      drain();

      c = '{charge_full_cv: '1, low_limit_cv: '1, disconnect_cv: '1,
            stepup_time_ms: '1, grace_time_ms: '1, no_supply_code: '1};
      program_config(c);
      run_groups(6, 3000);
      drain();

      for (int k = 0; k < 3; k++) begin
         program_config(random_setting());
         run_groups(6, 2000);
         drain();
      end

      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      c = '{charge_full_cv: 9'd300, low_limit_cv: 9'd260, disconnect_cv: 9'd40,
            stepup_time_ms: 32'd500, grace_time_ms: 32'd700, no_supply_code: 10'd1010};
      program_config(c);
      run_groups(8, 200);
      drain();

      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
